// ===== src/aose_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the per-opcode ALU function for the op-sequence evaluator.
package aose_pkg;

  localparam int MAX_OPS = 12;
  localparam int OP_W    = 4;
  localparam int OPS_W   = 48;
  localparam int LEN_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = $clog2(MAX_OPS + 1);

  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
  localparam logic [BYTE_W-1:0] SIGN_BIT  = 8'h80;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_AA = 4'd0,
    OP_ADD_AB = 4'd1,
    OP_SUB_B  = 4'd2,
    OP_LD_BA  = 4'd3,
    OP_ADC_AB = 4'd4,
    OP_ADC_AA = 4'd5,
    OP_SBC_AB = 4'd6,
    OP_SBC_AA = 4'd7,
    OP_SRL_A  = 4'd8,
    OP_RLA    = 4'd9,
    OP_RRA    = 4'd10,
    OP_RLCA   = 4'd11,
    OP_RRCA   = 4'd12,
    OP_NEG    = 4'd13,
    OP_NOP0   = 4'd14,
    OP_NOP1   = 4'd15
  } op_t;

  // Machine state carried by one item through the pipeline.
  typedef struct packed {
    logic [OPS_W-1:0]  ops;
    logic [CNT_W-1:0]  cnt;
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] breg;
    logic              cy;
  } item_t;

  // Executes one opcode on A, B and carry.
  function automatic item_t alu_step(input item_t cur, input op_t op);
    item_t         res;
    logic [BYTE_W:0] sum;
    res = cur;
    sum = '0;
    case (op)
      OP_ADD_AA: begin
        sum = {1'b0, cur.acc} + {1'b0, cur.acc};
        res.acc = sum[BYTE_W-1:0];
        res.cy  = sum[BYTE_W];
      end
      OP_ADD_AB: begin
        sum = {1'b0, cur.acc} + {1'b0, cur.breg};
        res.acc = sum[BYTE_W-1:0];
        res.cy  = sum[BYTE_W];
      end
      OP_SUB_B: begin
        sum = {1'b0, cur.acc} - {1'b0, cur.breg};
        res.acc = sum[BYTE_W-1:0];
        res.cy  = sum[BYTE_W];
      end
      OP_LD_BA: begin
        res.breg = cur.acc;
      end
      OP_ADC_AB: begin
        sum = {1'b0, cur.acc} + {1'b0, cur.breg} + {{BYTE_W{1'b0}}, cur.cy};
        res.acc = sum[BYTE_W-1:0];
        res.cy  = sum[BYTE_W];
      end
      OP_ADC_AA: begin
        sum = {1'b0, cur.acc} + {1'b0, cur.acc} + {{BYTE_W{1'b0}}, cur.cy};
        res.acc = sum[BYTE_W-1:0];
        res.cy  = sum[BYTE_W];
      end
      OP_SBC_AB: begin
        sum = {1'b0, cur.acc} - {1'b0, cur.breg} - {{BYTE_W{1'b0}}, cur.cy};
        res.acc = sum[BYTE_W-1:0];
        res.cy  = sum[BYTE_W];
      end
      OP_SBC_AA: begin
        res.acc = cur.cy ? BYTE_ONES : '0;
      end
      OP_SRL_A: begin
        res.cy  = cur.acc[0];
        res.acc = {1'b0, cur.acc[BYTE_W-1:1]};
      end
      OP_RLA: begin
        res.cy  = cur.acc[BYTE_W-1];
        res.acc = {cur.acc[BYTE_W-2:0], cur.cy};
      end
      OP_RRA: begin
        res.cy  = cur.acc[0];
        res.acc = {cur.cy, cur.acc[BYTE_W-1:1]};
      end
      OP_RLCA: begin
        res.cy  = (cur.acc & SIGN_BIT) != '0;
        res.acc = {cur.acc[BYTE_W-2:0], cur.acc[BYTE_W-1]};
      end
      OP_RRCA: begin
        res.cy  = cur.acc[0];
        res.acc = {cur.acc[0], cur.acc[BYTE_W-1:1]};
      end
      OP_NEG: begin
        res.cy  = cur.acc != '0;
        res.acc = '0 - cur.acc;
      end
      default: begin
        res = cur;
      end
    endcase
    return res;
  endfunction

endpackage

// ===== src/aose_stage.sv =====
`timescale 1ns / 1ps
// One pipeline stage: executes the next opcode of an item and registers the result.
module aose_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  aose_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output aose_pkg::item_t out_item
);
  import aose_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_nxt;
  item_t stepped;

  // A stage takes a new item when it is empty or its item moves on this cycle.
  assign in_ready = !valid_r || out_ready;

  always_comb begin
    stepped = alu_step(in_item, op_t'(in_item.ops[OP_W-1:0]));
    if (in_item.cnt != '0) begin
      item_nxt     = stepped;
      item_nxt.cnt = in_item.cnt - 1'b1;
    end else begin
      item_nxt = in_item;
    end
    // Slots past the packed field read as zero bits.
    item_nxt.ops = in_item.ops >> OP_W;
  end

  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== src/accumulator_op_sequence_evaluator_core.sv =====
`timescale 1ns / 1ps
// Top level of the accumulator op-sequence evaluator.
//
// The block runs a packed list of 4-bit opcodes on an 8-bit accumulator A, a
// register B and a carry flag, starting from A = in_initial_value, B = 0 and
// carry = 0, and returns the final A on out_result_value.
// Both channels use a valid/ready handshake; an item moves at a rising edge at
// which valid and ready are both high.
// The datapath is a chain of MAX_OPS stages (twelve), one opcode slot each, and
// each stage registers its item. An item can enter in every cycle while the
// receiver takes results, giving a throughput of one item per cycle.
// Items with fewer opcodes still pass through every stage; the stages past the
// last opcode only carry the item along.
// Each stage is ready when it is empty or its item is moving on, so bubbles
// collapse: while the receiver stalls, input keeps being accepted until every
// stage holds an item, and nothing is lost or repeated.
// Reset clears the stage valid bits only; the item registers are not reset.
module accumulator_op_sequence_evaluator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [aose_pkg::OPS_W-1:0]  in_ops_packed,
  input  logic [aose_pkg::LEN_W-1:0]  in_seq_length,
  input  logic [aose_pkg::BYTE_W-1:0] in_initial_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [aose_pkg::BYTE_W-1:0] out_result_value
);
  import aose_pkg::*;

  // Link k feeds stage k; link MAX_OPS is the output of the last stage.
  logic  link_valid [MAX_OPS+1];
  logic  link_ready [MAX_OPS+1];
  item_t link_item  [MAX_OPS+1];

  logic [CNT_W-1:0] len_sat;

  // Lengths above MAX_OPS saturate. The compare is done one bit wider than
  // either operand so that it stays exact for any MAX_OPS in range.
  always_comb begin
    if ({1'b0, (CNT_W + LEN_W)'(in_seq_length)} > (CNT_W + LEN_W + 1)'(MAX_OPS)) begin
      len_sat = CNT_W'(MAX_OPS);
    end else begin
      len_sat = CNT_W'(in_seq_length);
    end
  end

  // A new item starts with B and carry cleared.
  assign link_item[0] = '{ops:  in_ops_packed,
                          cnt:  len_sat,
                          acc:  in_initial_value,
                          breg: '0,
                          cy:   1'b0};

  assign link_valid[0] = in_valid;
  assign in_ready      = link_ready[0];

  for (genvar k = 0; k < MAX_OPS; k++) begin : g_stage
    aose_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_item   (link_item[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_item  (link_item[k+1])
    );
  end

  // The last stage's register is the output register.
  assign link_ready[MAX_OPS] = out_ready;
  assign out_valid           = link_valid[MAX_OPS];
  assign out_result_value    = link_item[MAX_OPS].acc;

endmodule

// ===== src/aose_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the op-sequence evaluator, bound to the top level.
module aose_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [aose_pkg::OPS_W-1:0]  in_ops_packed,
  input logic [aose_pkg::LEN_W-1:0]  in_seq_length,
  input logic [aose_pkg::BYTE_W-1:0] in_initial_value,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [aose_pkg::BYTE_W-1:0] out_result_value
);
  import aose_pkg::*;

  logic [OPS_W+LEN_W+BYTE_W-1:0] in_bus;
  assign in_bus = {in_ops_packed, in_seq_length, in_initial_value};

  // A waiting result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("result changed or vanished while stalled");

  // An offered item stays put until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_bus))
    else $error("input item changed or vanished while stalled");

  // The pipeline empties at reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With the receiver taking results, the pipeline never back-pressures.
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled although the receiver is ready");

  // Input is refused only when every stage is full and the output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without a blocked output");

endmodule

bind accumulator_op_sequence_evaluator_core aose_checker u_aose_checker (.*);
